[rtl/b64lw_pkg.sv]
// Package for the line-wrapped base64 encoder.
// Holds the character constants, the phase codes, the result-pack type and
// the alphabet function. No dependencies.
`timescale 1ns / 1ps

package b64lw_pkg;

  // Width of the completed-group counter
  localparam int unsigned LineCntW = 5;

  // Position of the next byte within its three-byte group
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Special characters
  localparam logic [7:0] CHAR_PAD = 8'h23;  // '#'
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_PLS = 8'h2b;  // '+'
  localparam logic [7:0] CHAR_MIN = 8'h2d;  // '-'

  // Up to four characters produced by one input byte
  typedef struct packed {
    logic [3:0][7:0] chars;     // chars[0] goes out first
    logic [1:0]      last_idx;  // index of the final character
  } pack_t;

  // Map a 6-bit value onto the alphabet A-Z a-z 0-9 + -
  function automatic logic [7:0] b64_sym(input logic [5:0] six);
    logic [7:0] v;
    v = {2'b00, six};
    if (six < 6'd26) begin
      return 8'(8'h41 + v);
    end else if (six < 6'd52) begin
      return 8'(8'h61 + v - 8'd26);
    end else if (six < 6'd62) begin
      return 8'(8'h30 + v - 8'd52);
    end else if (six == 6'd62) begin
      return CHAR_PLS;
    end else begin
      return CHAR_MIN;
    end
  endfunction

endpackage

[rtl/b64lw_encode.sv]
// Encoder stage: group phase, held bits and line counter, plus the pack
// register that holds the characters for one accepted byte.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_encode import b64lw_pkg::*; #(
  parameter int unsigned GROUPS_PER_LINE = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       pk_valid_o,
  output pack_t      pk_o,
  input  logic       pk_take_i
);

  logic [1:0]          phase_q, phase_d;
  logic [3:0]          held_q, held_d;
  logic [LineCntW-1:0] groups_q, groups_d;
  logic                pk_valid_q, pk_valid_d;
  pack_t               pk_q, pk_d;
  logic [LineCntW-1:0] groups_inc;
  logic                accept;

  // Pack register frees up when the serializer takes it
  assign in_ready_o = !pk_valid_q || pk_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign groups_inc = groups_q + LineCntW'(1);

  // Characters and next state for the incoming byte
  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    groups_d = groups_q;
    pk_d     = '0;
    case (phase_q)
      PH_SECOND: begin
        pk_d.chars[0] = b64_sym({held_q[1:0], data_byte_i[7:4]});
        pk_d.last_idx = 2'd0;
        held_d        = data_byte_i[3:0];
        phase_d       = PH_THIRD;
        if (last_byte_i) begin
          pk_d.chars[1] = b64_sym({data_byte_i[3:0], 2'b00});
          pk_d.chars[2] = CHAR_PAD;
          pk_d.last_idx = 2'd2;
        end
      end
      PH_THIRD: begin
        pk_d.chars[0] = b64_sym({held_q, data_byte_i[7:6]});
        pk_d.chars[1] = b64_sym(data_byte_i[5:0]);
        pk_d.last_idx = 2'd1;
        held_d        = 4'd0;
        phase_d       = PH_FIRST;
        groups_d      = groups_inc;
        // line full: break and restart the count
        if (groups_inc >= LineCntW'(GROUPS_PER_LINE)) begin
          groups_d      = '0;
          pk_d.chars[2] = CHAR_CR;
          pk_d.chars[3] = CHAR_LF;
          pk_d.last_idx = 2'd3;
        end
      end
      default: begin
        // first byte of a group; the unused code acts the same
        pk_d.chars[0] = b64_sym(data_byte_i[7:2]);
        pk_d.last_idx = 2'd0;
        held_d        = {2'b00, data_byte_i[1:0]};
        phase_d       = PH_SECOND;
        if (last_byte_i) begin
          pk_d.chars[1] = b64_sym({data_byte_i[1:0], 4'b0000});
          pk_d.chars[2] = CHAR_PAD;
          pk_d.chars[3] = CHAR_PAD;
          pk_d.last_idx = 2'd3;
        end
      end
    endcase
    // end of message: back to a fresh start
    if (last_byte_i) begin
      phase_d  = PH_FIRST;
      held_d   = 4'd0;
      groups_d = '0;
    end
  end

  // Pack valid flag
  always_comb begin
    pk_valid_d = pk_valid_q;
    if (accept) begin
      pk_valid_d = 1'b1;
    end else if (pk_take_i) begin
      pk_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      held_q     <= 4'd0;
      groups_q   <= '0;
      pk_valid_q <= 1'b0;
    end else begin
      pk_valid_q <= pk_valid_d;
      if (accept) begin
        phase_q  <= phase_d;
        held_q   <= held_d;
        groups_q <= groups_d;
      end
    end
  end

  // Pack payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pk_q <= pk_d;
    end
  end

  assign pk_valid_o = pk_valid_q;
  assign pk_o       = pk_q;

endmodule

[rtl/b64lw_serial.sv]
// Serializer: holds the pack being sent and walks through its characters,
// one per output request, flagging the final one.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_serial import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pk_valid_i,
  input  pack_t      pk_i,
  output logic       pk_take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       end_of_run_o
);

  logic       cur_valid_q, cur_valid_d;
  pack_t      cur_q;
  logic [1:0] idx_q, idx_d;
  logic       fire, at_last;

  assign at_last   = (idx_q == cur_q.last_idx);
  assign fire      = cur_valid_q && out_ready_i;
  // Load the next pack once the current one is empty or finishing
  assign pk_take_o = pk_valid_i && (!cur_valid_q || (fire && at_last));

  // Index and valid update
  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pk_take_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
    end else if (fire) begin
      if (at_last) begin
        cur_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pk_take_o) begin
      cur_q <= pk_i;
    end
  end

  assign out_valid_o  = cur_valid_q;
  assign out_char_o   = cur_q.chars[idx_q];
  assign end_of_run_o = at_last;

endmodule

[rtl/base64_encoder_line_wrapped_core.sv]
// Line-wrapped base64 encoder, one byte in, one to four characters out.
// A byte's characters pass through the encoder's pack register and then the
// serializer's current-pack register, loaded once the serializer is free.
// Throughput: one character per cycle on the output while m_axis_tready_i is
// high; a byte yields 1 to 4 characters, about 1.4 on average.
// Reset (rst_ni low, asynchronous) clears group phase, held bits, line count.
`timescale 1ns / 1ps

module base64_encoder_line_wrapped_core import b64lw_pkg::*; #(
  parameter int unsigned GROUPS_PER_LINE = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o    // end_of_run
);

  logic  pk_valid;
  pack_t pk;
  logic  pk_take;

  // Byte to character pack
  b64lw_encode #(
    .GROUPS_PER_LINE(GROUPS_PER_LINE)
  ) u_encode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .data_byte_i(s_axis_tdata_i),
    .last_byte_i(s_axis_tlast_i),
    .pk_valid_o (pk_valid),
    .pk_o       (pk),
    .pk_take_i  (pk_take)
  );

  // Pack to character stream
  b64lw_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pk_valid_i  (pk_valid),
    .pk_i        (pk),
    .pk_take_o   (pk_take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .end_of_run_o(m_axis_tlast_o)
  );

endmodule

[sim/base64_encoder_line_wrapped_core_test.sv]
// Self-checking bench for base64_encoder_line_wrapped_core: byte stream in,
// encoded characters out, checked against an in-bench encoder model.
// Depends on rtl/b64lw_pkg.sv and rtl/base64_encoder_line_wrapped_core.sv.
`timescale 1ns / 1ps

module base64_encoder_line_wrapped_core_test;
  import b64lw_pkg::*;

  localparam int unsigned LineGroups = 20;
  localparam int unsigned RandBytes  = 186;
  localparam int unsigned CycleLimit = 400000;

  // One expected output character
  typedef struct {
    logic [7:0] ch;
    logic       eor;
  } enc_char_t;

  // Encoder model plus queue of characters still owed by the block
  class b64_char_board;
    logic [1:0]          phase;
    logic [3:0]          held;
    logic [LineCntW-1:0] line_groups;
    enc_char_t           owed_chars[$];
    int unsigned         mismatches;
    int unsigned         char_idx;
    string               alpha;

    function new();
      alpha = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
               "0123456789+-"};
      phase       = PH_FIRST;
      held        = '0;
      line_groups = '0;
      mismatches  = 0;
      char_idx    = 0;
    endfunction

    function logic [7:0] enc_sym(logic [5:0] six);
      return 8'(alpha[six]);
    endfunction

    task report(string msg);
      $display("mismatch on char %0d: %s", char_idx, msg);
      mismatches++;
    endtask

    // Accepted byte request: work out every character it yields
    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0] chars[$];
      enc_char_t  e;
      case (phase)
        PH_SECOND: begin
          chars.push_back(enc_sym({held[1:0], b[7:4]}));
          held  = b[3:0];
          phase = PH_THIRD;
          if (fin) begin
            chars.push_back(enc_sym({held, 2'b00}));
            chars.push_back(CHAR_PAD);
          end
        end
        PH_THIRD: begin
          chars.push_back(enc_sym({held, b[7:6]}));
          chars.push_back(enc_sym(b[5:0]));
          held        = '0;
          phase       = PH_FIRST;
          line_groups = line_groups + 1'b1;
          if (line_groups >= LineGroups) begin
            line_groups = '0;
            chars.push_back(CHAR_CR);
            chars.push_back(CHAR_LF);
          end
        end
        default: begin
          // unreachable phase 3 folds into the first position
          chars.push_back(enc_sym(b[7:2]));
          held  = {2'b00, b[1:0]};
          phase = PH_SECOND;
          if (fin) begin
            chars.push_back(enc_sym({held[1:0], 4'b0000}));
            chars.push_back(CHAR_PAD);
            chars.push_back(CHAR_PAD);
          end
        end
      endcase
      if (fin) begin
        phase       = PH_FIRST;
        held        = '0;
        line_groups = '0;
      end
      foreach (chars[i]) begin
        e.ch  = chars[i];
        e.eor = (i == chars.size() - 1);
        owed_chars.push_back(e);
      end
    endfunction

    // Accepted character: compare against the oldest owed one
    task check_char(logic [7:0] ch, logic eor);
      enc_char_t e;
      if (owed_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h tlast %0b", ch, eor));
      end else begin
        e = owed_chars.pop_front();
        if (ch !== e.ch)
          report($sformatf("char 0x%02h, want 0x%02h", ch, e.ch));
        if (eor !== e.eor)
          report($sformatf("tlast %0b, want %0b", eor, e.eor));
      end
      char_idx++;
    endtask
  endclass

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_valid  = 1'b0;
  logic [7:0] s_data   = 8'h00;
  logic       s_last   = 1'b0;
  logic       m_ready  = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  b64_char_board board = new();

  int unsigned burst_left = 0;
  int unsigned cycles     = 0;
  int unsigned rx_tick    = 0;
  int unsigned rx_mode    = 0;
  logic [31:0] rx_pat     = 32'h1;

  always #5 clk_i = ~clk_i;

  base64_encoder_line_wrapped_core #(
    .GROUPS_PER_LINE(LineGroups)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: check accepted characters, stall in a randomly chosen mode
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      board.check_char(m_axis_tdata_o, m_axis_tlast_o);
    rx_tick++;
    if (rx_tick % 64 == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_pat  = $urandom | 32'h1;
    end
    rx_pat = {rx_pat[30:0], rx_pat[31]};
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= rx_pat[0];
      2:       m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= rx_pat[0] | rx_pat[1];
    endcase
  end

  // Send one byte request; bursts of random length with random gaps between
  task automatic push_byte(input logic [7:0] d, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= d;
    s_last  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(d, fin);
  endtask

  task automatic push_msg(input logic [7:0] bytes[$]);
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned sel;
    logic [7:0]  msg[$];

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one- and two-byte tails at the extremes, full groups that
    // hit the last two alphabet entries, final byte closing a group
    push_msg('{8'h00});
    push_msg('{8'hff});
    push_msg('{8'h00, 8'hff});
    push_msg('{8'hff, 8'h00});
    push_msg('{8'hfb, 8'hef, 8'hbe});
    push_msg('{8'hff, 8'hff, 8'hff});
    push_msg('{8'h00, 8'h10, 8'h83, 8'h10, 8'h51, 8'h87});
    push_msg('{8'h55, 8'haa, 8'h0f, 8'hf0});
    push_msg('{8'h01, 8'h80});

    // Random messages: mostly short, some long enough to wrap lines,
    // with lengths around the wrap point so the last byte can close a line
    sent = 0;
    while (sent < RandBytes) begin
      sel = $urandom_range(0, 9);
      msg.delete();
      if (sel < 2) len = $urandom_range(57, 65);
      else if (sel == 2) len = 1;
      else if (sel == 9) len = $urandom_range(118, 124);
      else len = $urandom_range(1, 9);
      if (len > RandBytes - sent) len = RandBytes - sent;
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      push_msg(msg);
      sent += len;
    end

    // Drop valid right at the final acceptance edge
    s_valid <= 1'b0;
    while (board.owed_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
